[rtl/rop_pkg.sv]
`default_nettype none
package rop_pkg;
  localparam int FRAC_BITS_DEF = 16;
  localparam int CORDIC_STAGES_DEF = 16;
  localparam int ANG_BITS = 30;
  localparam int DATA_W = 32;
  localparam int DECAY_W = 17;
  localparam int TS_W = 24;
  localparam int TH_W = 19;
  localparam int ZW = 34;
  localparam int CW = 33;
  localparam logic signed [ZW-1:0] PI_Q30 = 34'sd3373259426;
  localparam logic signed [ZW-1:0] HALF_PI_Q30 = 34'sd1686629713;
  localparam logic signed [ZW-1:0] TWO_PI_Q30 = 34'sd6746518852;
  localparam logic signed [CW-1:0] GAIN_INV_Q30 = 33'sd652032874;

  function automatic logic signed [ZW-1:0] atan_q30(input int i);
    logic signed [ZW-1:0] r;
    r = '0;
    case (i)
      0: r = 34'sd843314857;
      1: r = 34'sd497837829;
      2: r = 34'sd263043837;
      3: r = 34'sd133525159;
      4: r = 34'sd67021687;
      5: r = 34'sd33543516;
      6: r = 34'sd16775851;
      7: r = 34'sd8388437;
      8: r = 34'sd4194283;
      9: r = 34'sd2097149;
      default: r = (i < 30) ? (34'sd1 <<< (30 - i)) : '0;
    endcase
    return r;
  endfunction

  function automatic logic signed [DATA_W-1:0] sat32(input logic signed [67:0] v);
    logic signed [DATA_W-1:0] r;
    r = v[DATA_W-1:0];
    if (v > 68'sd2147483647) r = 32'sh7fffffff;
    else if (v < -68'sd2147483648) r = 32'sh80000000;
    return r;
  endfunction
endpackage
`default_nettype wire

[rtl/rop_cordic_cell.sv]
`default_nettype none
module rop_cordic_cell
  import rop_pkg::*;
#(
  parameter int IDX = 0
) (
  input  wire                  clk,
  input  wire signed [CW-1:0]  x_i,
  input  wire signed [CW-1:0]  y_i,
  input  wire signed [ZW-1:0]  z_i,
  output logic signed [CW-1:0] x_o,
  output logic signed [CW-1:0] y_o,
  output logic signed [ZW-1:0] z_o
);
  // one micro-rotation per cell, registered toward the neighbor
  always_ff @(posedge clk) begin
    if (z_i >= 0) begin
      x_o <= x_i - (y_i >>> IDX);
      y_o <= y_i + (x_i >>> IDX);
      z_o <= z_i - atan_q30(IDX);
    end else begin
      x_o <= x_i + (y_i >>> IDX);
      y_o <= y_i - (x_i >>> IDX);
      z_o <= z_i + atan_q30(IDX);
    end
  end
endmodule
`default_nettype wire

[rtl/relative_object_predict.sv]
`default_nettype none
// Constant-velocity predictor for one tracked object, corrected for observer
// odometry. Position advances by time_step*velocity, velocity scales by
// velocity_decay, then position rotates by -dtheta and velocity by +dtheta
// (sine/cosine from a row of CORDIC cells), and the observer translation is
// subtracted. A request is taken every cycle (busy stays low); its result
// is on the outputs in the same cycle that done is high for one cycle. The
// receiver cannot stall, so results must be taken when done is high. Latency
// is set by the prescale register, the CORDIC cell row (with the advance
// register beside its first cell) and the rotate-multiply, sum and output
// registers. velocity_decay may be written any time the pipe is empty.
module relative_object_predict
  import rop_pkg::*;
#(
  parameter int FRAC_BITS = FRAC_BITS_DEF,
  parameter int CORDIC_STAGES = CORDIC_STAGES_DEF
) (
  input  wire                      clk,
  input  wire                      rst,
  input  wire                      start,
  output logic                     busy,
  input  wire signed [DATA_W-1:0]  pos_x_in,
  input  wire signed [DATA_W-1:0]  pos_y_in,
  input  wire signed [DATA_W-1:0]  vel_x_in,
  input  wire signed [DATA_W-1:0]  vel_y_in,
  input  wire [TS_W-1:0]           time_step,
  input  wire signed [DATA_W-1:0]  odo_dx,
  input  wire signed [DATA_W-1:0]  odo_dy,
  input  wire signed [TH_W-1:0]    odo_dtheta,
  input  wire                      cfg_valid,
  output logic                     cfg_ready,
  input  wire [DECAY_W-1:0]        cfg_data,
  output logic                     done,
  output logic signed [DATA_W-1:0] pos_x_out,
  output logic signed [DATA_W-1:0] pos_y_out,
  output logic signed [DATA_W-1:0] vel_x_out,
  output logic signed [DATA_W-1:0] vel_y_out
);
  localparam int DEPTH = CORDIC_STAGES + 4;
  localparam int RSH = ANG_BITS - FRAC_BITS;
  localparam logic [DECAY_W-1:0] DECAY_RESET =
    DECAY_W'(((96 * (64'd1 << FRAC_BITS)) + 50) / 100);
  localparam logic signed [67:0] HALF = 68'sd1 <<< (FRAC_BITS - 1);

  logic [DECAY_W-1:0] velocity_decay;
  logic [DEPTH-1:0] vld;

  assign busy = 1'b0;
  assign cfg_ready = 1'b1;

  // hold decay register
  always_ff @(posedge clk) begin
    if (rst) velocity_decay <= DECAY_RESET;
    else if (cfg_valid && cfg_ready) velocity_decay <= cfg_data;
  end

  // advance valid marks along the pipe
  always_ff @(posedge clk) begin
    if (rst) vld <= '0;
    else vld <= {vld[DEPTH-2:0], start};
  end

  // stage 0: angle folding, products for advance and decay
  logic signed [ZW-1:0] z_raw, z_wr, z_f;
  logic flip_c;
  always_comb begin
    z_raw = ZW'(odo_dtheta) <<< RSH;
    z_wr = z_raw;
    if (z_raw > PI_Q30) z_wr = z_raw - TWO_PI_Q30;
    else if (z_raw < -PI_Q30) z_wr = z_raw + TWO_PI_Q30;
    z_f = z_wr;
    flip_c = 1'b0;
    if (z_wr > HALF_PI_Q30) begin
      z_f = z_wr - PI_Q30; flip_c = 1'b1;
    end else if (z_wr < -HALF_PI_Q30) begin
      z_f = z_wr + PI_Q30; flip_c = 1'b1;
    end
  end

  logic signed [57:0] tvx, tvy;
  logic signed [50:0] dvx, dvy;
  logic signed [DATA_W-1:0] p0x, p0y, dx0, dy0;
  logic signed [ZW-1:0] z0;
  logic f0;
  always_ff @(posedge clk) begin
    tvx <= $signed({1'b0, time_step}) * vel_x_in;
    tvy <= $signed({1'b0, time_step}) * vel_y_in;
    dvx <= $signed({1'b0, velocity_decay}) * vel_x_in;
    dvy <= $signed({1'b0, velocity_decay}) * vel_y_in;
    p0x <= pos_x_in; p0y <= pos_y_in;
    dx0 <= odo_dx; dy0 <= odo_dy;
    z0 <= z_f; f0 <= flip_c;
  end

  // stage 1: round, saturate advanced state
  logic signed [DATA_W-1:0] ax, ay, bx, by;
  always_ff @(posedge clk) begin
    ax <= sat32(68'(p0x) + ((68'(tvx) + HALF) >>> FRAC_BITS));
    ay <= sat32(68'(p0y) + ((68'(tvy) + HALF) >>> FRAC_BITS));
    bx <= sat32((68'(dvx) + HALF) >>> FRAC_BITS);
    by <= sat32((68'(dvy) + HALF) >>> FRAC_BITS);
  end

  // CORDIC cell row; side data rides a delay line alongside
  logic signed [CW-1:0] cx [CORDIC_STAGES+1];
  logic signed [CW-1:0] cy [CORDIC_STAGES+1];
  logic signed [ZW-1:0] cz [CORDIC_STAGES+1];
  assign cx[0] = GAIN_INV_Q30;
  assign cy[0] = '0;
  assign cz[0] = z0;
  for (genvar g = 0; g < CORDIC_STAGES; g++) begin : g_cell
    rop_cordic_cell #(.IDX(g)) u_cell (
      .clk(clk), .x_i(cx[g]), .y_i(cy[g]), .z_i(cz[g]),
      .x_o(cx[g+1]), .y_o(cy[g+1]), .z_o(cz[g+1])
    );
  end

  typedef struct packed {
    logic signed [DATA_W-1:0] px, py, vx, vy, dx, dy;
    logic flip;
  } side_t;
  side_t sd [CORDIC_STAGES];
  logic f1, f0d;
  logic signed [DATA_W-1:0] dx1, dy1;
  always_ff @(posedge clk) begin
    f1 <= f0; dx1 <= dx0; dy1 <= dy0;
  end
  assign f0d = f1;
  // side line starts at the stage 1 registers, beside the first cell; cells start at z0
  // so CORDIC_STAGES-1 side registers after stage 1 align it at row end
  always_comb begin
    sd[0] = '{px: ax, py: ay, vx: bx, vy: by, dx: dx1, dy: dy1, flip: f0d};
  end
  for (genvar g = 0; g < CORDIC_STAGES - 1; g++) begin : g_side
    always_ff @(posedge clk) sd[g+1] <= sd[g];
  end
  side_t sa;
  assign sa = sd[CORDIC_STAGES-1];

  // round sin/cos to FRAC_BITS and apply flip
  logic signed [CW-1:0] xr, yr;
  logic signed [CW-1:0] c_v, s_v;
  assign xr = (cx[CORDIC_STAGES] + (CW'(1) <<< (RSH - 1))) >>> RSH;
  assign yr = (cy[CORDIC_STAGES] + (CW'(1) <<< (RSH - 1))) >>> RSH;
  assign c_v = sa.flip ? -xr : xr;
  assign s_v = sa.flip ? -yr : yr;

  // rotate: eight products, registered
  logic signed [65:0] m_pc, m_ps, m_qc, m_qs, m_vc, m_vs, m_wc, m_ws;
  side_t sb;
  always_ff @(posedge clk) begin
    m_pc <= sa.px * c_v; m_ps <= sa.px * s_v;
    m_qc <= sa.py * c_v; m_qs <= sa.py * s_v;
    m_vc <= sa.vx * c_v; m_vs <= sa.vx * s_v;
    m_wc <= sa.vy * c_v; m_ws <= sa.vy * s_v;
    sb <= sa;
  end

  logic signed [DATA_W-1:0] rx, ry, wx, wy;
  side_t sc;
  always_ff @(posedge clk) begin
    rx <= sat32((68'(m_pc) + 68'(m_qs) + HALF) >>> FRAC_BITS);
    ry <= sat32((68'(m_qc) - 68'(m_ps) + HALF) >>> FRAC_BITS);
    wx <= sat32((68'(m_vc) - 68'(m_ws) + HALF) >>> FRAC_BITS);
    wy <= sat32((68'(m_vs) + 68'(m_wc) + HALF) >>> FRAC_BITS);
    sc <= sb;
  end

  // drop observer translation; final velocity is registered alongside
  always_ff @(posedge clk) begin
    pos_x_out <= sat32(68'(rx) - 68'(sc.dx));
    pos_y_out <= sat32(68'(ry) - 68'(sc.dy));
    vel_x_out <= wx;
    vel_y_out <= wy;
  end

  assign done = vld[DEPTH-1];
endmodule
`default_nettype wire
